// ===== src/scst_pkg.sv =====
// Shared types, codes and defaults of the shadow call stack tracker.
package scst_pkg;

   localparam int STACK_DEPTH_DEF   = 32;
   localparam int FUNC_ID_WIDTH_DEF = 32;

   localparam logic [1:0] EXIT_NONE  = 2'd0;
   localparam logic [1:0] EXIT_RET   = 2'd1;
   localparam logic [1:0] EXIT_CALL  = 2'd2;
   localparam logic [1:0] EXIT_OTHER = 2'd3;

   localparam logic [1:0] EV_ENTER = 2'd0;
   localparam logic [1:0] EV_EXIT  = 2'd1;
   localparam logic [1:0] EV_DROP  = 2'd2;

   typedef struct packed {
      logic [1:0]  prev_exit;
      logic [63:0] target;
      logic [63:0] stack_pointer;
      logic [63:0] call_site_return;
      logic        entry_block;
      logic        crossed_boundary;
      logic        prev_was_resolver;
      logic [31:0] func_id;
   } req_type;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [31:0] event_func;
      logic [5:0]  depth_after;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] sp;
      logic [63:0] ret;
      logic [31:0] func;
   } frame_type;

   typedef enum logic [2:0] {
      CELL_HOLD       = 3'd0,
      CELL_PUSH       = 3'd1,
      CELL_POP        = 3'd2,
      CELL_SETRET     = 3'd3,
      CELL_SCAN_START = 3'd4,
      CELL_SCAN_STEP  = 3'd5
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic [63:0] csp;
      logic [63:0] target;
      logic [63:0] ret_value;
      logic        set_ret;
   } cell_ctl_type;

endpackage

// ===== src/shadow_call_stack_tracker.sv =====
// Top level of the shadow call stack tracker: sequencer over a chain of stack cells.
//
// Usage: one req beat per executed basic block (req_data, type req_type). The block
// answers with zero or more rsp beats (rsp_type): function entered, function exited,
// or a push dropped at full depth; the final beat of a block carries last = 1, and a
// block that causes no event gives no beat at all.
// The stack is a chain of STACK_DEPTH+1 cells, the top frame in cell 0 and the base
// entry below the live frames; push and pop shift the whole chain by one cell.
// Timing: one block is handled at a time; req_stall is high until it is finished.
// A block passes through classification, the emulation step unless it is taken as a
// real return, the return-address scan (one cell per cycle) where it applies, one pop
// step per frame popped, a push step when a frame is pushed or a push is dropped, and
// a final step that closes the block.
// Each event beat waits in a pending register until the next event of the block or
// the block's last cycle, then moves to the rsp register; that is how the last beat
// gets marked.
// Stall: while rsp_valid is high and rsp_stall is high, every step that would make a
// beat or move the stack holds; the scan keeps walking.
// Reset: synchronous; clears the stack to the bare base entry, depth zero, and drops
// any beat in flight.
module shadow_call_stack_tracker
   import scst_pkg::*;
#(
   parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
   parameter int FUNC_ID_WIDTH = FUNC_ID_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int NCELL = STACK_DEPTH + 1;
   localparam int DW    = $clog2(STACK_DEPTH + 1);
   localparam logic [DW-1:0] DEPTH_FULL = DW'(STACK_DEPTH);
   localparam logic [31:0] FUNC_MASK = (FUNC_ID_WIDTH >= 32) ? 32'hFFFF_FFFF :
                                       32'((64'd1 << FUNC_ID_WIDTH) - 64'd1);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_CLASS = 7'b0000010,
      ST_SCAN  = 7'b0000100,
      ST_EMUL  = 7'b0001000,
      ST_POP   = 7'b0010000,
      ST_PUSH  = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type    state_ff, state_in;
   req_type      in_ff, in_in;
   logic [31:0]  func_ff, func_in;
   logic [63:0]  csp_ff, csp_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic         retcall_ff, retcall_in;
   logic         emul_ff, emul_in;
   logic         is_ret_ff, is_ret_in;
   logic         is_call_ff, is_call_in;
   logic         walk_ff, walk_in;
   logic         cnt_ff, cnt_in;
   logic         popped_ff, popped_in;
   logic         hold_v_ff, hold_v_in;
   rsp_type      hold_ff, hold_in;
   logic         rsp_v_ff, rsp_v_in;
   rsp_type      rsp_ff, rsp_in;

   cell_ctl_type ctl;
   frame_type    new_frame;
   frame_type    frame_w [NCELL];
   frame_type    up_w    [NCELL];
   frame_type    down_w  [NCELL];
   logic [NCELL-1:0] scan_w;
   logic [NCELL-1:0] hit_w;
   logic [NCELL-1:0] up_scan_w;

   logic         step;
   logic         ev_v;
   logic [1:0]   ev_kind;
   logic [31:0]  ev_func;
   logic [DW+5:0] depth_x;
   frame_type    top;
   logic         found;
   logic         scan_any;
   logic         emul_cond;

   // Chain wiring: cell 0 takes the new frame on push, the bottom takes an empty one on pop.
   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      if (k == 0) begin : g_top
         assign up_w[k]      = new_frame;
         assign up_scan_w[k] = 1'b0;
      end else if (k == 1) begin : g_second
         always_comb begin
            up_w[k] = frame_w[0];
            if (ctl.set_ret) begin
               up_w[k].ret = ctl.ret_value;
            end
         end
         assign up_scan_w[k] = scan_w[0];
      end else begin : g_rest
         assign up_w[k]      = frame_w[k-1];
         assign up_scan_w[k] = scan_w[k-1];
      end
      if (k == NCELL - 1) begin : g_bottom
         assign down_w[k] = '0;
      end else begin : g_inner
         assign down_w[k] = frame_w[k+1];
      end

      scst_cell #(
         .IS_TOP (k == 0)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .up_frame   (up_w[k]),
         .down_frame (down_w[k]),
         .up_scan    (up_scan_w[k]),
         .frame_out  (frame_w[k]),
         .scan_out   (scan_w[k]),
         .hit        (hit_w[k])
      );
   end

   assign top      = frame_w[0];
   assign found    = |hit_w;
   assign scan_any = |scan_w;
   assign step     = !rsp_v_ff || !rsp_stall;
   assign emul_cond = (in_ff.prev_exit == EXIT_OTHER || retcall_ff) &&
                      (retcall_ff || in_ff.crossed_boundary || in_ff.entry_block);

   always_comb begin
      state_in   = state_ff;
      in_in      = in_ff;
      func_in    = func_ff;
      csp_in     = csp_ff;
      depth_in   = depth_ff;
      retcall_in = retcall_ff;
      emul_in    = emul_ff;
      is_ret_in  = is_ret_ff;
      is_call_in = is_call_ff;
      walk_in    = walk_ff;
      cnt_in     = cnt_ff;
      popped_in  = popped_ff;
      hold_v_in  = hold_v_ff;
      hold_in    = hold_ff;
      rsp_v_in   = rsp_v_ff && rsp_stall;
      rsp_in     = rsp_ff;

      ctl.op        = CELL_HOLD;
      ctl.csp       = csp_ff;
      ctl.target    = in_ff.target;
      ctl.ret_value = in_ff.call_site_return;
      ctl.set_ret   = 1'b0;
      new_frame     = '0;
      ev_v          = 1'b0;
      ev_kind       = EV_ENTER;
      ev_func       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               in_in      = req_data;
               func_in    = req_data.func_id & FUNC_MASK;
               csp_in     = req_data.stack_pointer;
               retcall_in = 1'b0;
               emul_in    = 1'b0;
               is_ret_in  = 1'b0;
               is_call_in = 1'b0;
               walk_in    = 1'b0;
               cnt_in     = 1'b0;
               popped_in  = 1'b0;
               state_in   = ST_CLASS;
            end
         end
         ST_CLASS: begin
            if (step) begin
               if (in_ff.prev_exit == EXIT_RET) begin
                  if (csp_ff < top.sp) begin
                     retcall_in = 1'b1;
                     state_in   = ST_EMUL;
                  end else if (csp_ff == top.sp) begin
                     ctl.op   = CELL_SCAN_START;
                     state_in = ST_SCAN;
                  end else begin
                     is_ret_in = 1'b1;
                     cnt_in    = 1'b1;
                     walk_in   = 1'b0;
                     state_in  = ST_POP;
                  end
               end else begin
                  state_in = ST_EMUL;
               end
            end
         end
         ST_SCAN: begin
            // Walk frames of equal stack pointer, one cell per cycle, for a matching return.
            // No beat is made here, so keep walking under rsp stall.
            if (found) begin
               is_ret_in = 1'b1;
               cnt_in    = 1'b1;
               walk_in   = 1'b1;
               state_in  = ST_POP;
            end else if (!scan_any) begin
               retcall_in = 1'b1;
               state_in   = ST_EMUL;
            end else begin
               ctl.op = CELL_SCAN_STEP;
            end
         end
         ST_EMUL: begin
            if (step) begin
               if (emul_cond) begin
                  emul_in    = 1'b1;
                  is_call_in = 1'b1;
                  // Drop the resolver's frame and resume at its stack pointer.
                  if (depth_ff != '0 && in_ff.prev_was_resolver) begin
                     ctl.op   = CELL_POP;
                     csp_in   = top.sp;
                     depth_in = depth_ff - 1'b1;
                     ev_v     = (top.func != '0);
                     ev_kind  = EV_EXIT;
                     ev_func  = top.func;
                  end
               end else begin
                  is_call_in = (in_ff.prev_exit == EXIT_CALL);
               end
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            if (step) begin
               if (depth_ff != '0 &&
                   (csp_ff > top.sp || (csp_ff == top.sp && cnt_ff))) begin
                  ctl.op    = CELL_POP;
                  depth_in  = depth_ff - 1'b1;
                  popped_in = 1'b1;
                  ev_v      = (top.func != '0);
                  ev_kind   = EV_EXIT;
                  ev_func   = top.func;
                  if (cnt_ff && (!walk_ff || top.ret == in_ff.target)) begin
                     cnt_in = 1'b0;
                  end
               end else if (is_ret_ff || popped_ff) begin
                  state_in = ST_DONE;
               end else if (is_call_ff) begin
                  state_in = ST_PUSH;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_PUSH: begin
            if (step) begin
               ctl.set_ret = (in_ff.prev_exit == EXIT_CALL);
               if (depth_ff == DEPTH_FULL) begin
                  if (ctl.set_ret) begin
                     ctl.op = CELL_SETRET;
                  end
                  ev_v    = 1'b1;
                  ev_kind = EV_DROP;
                  ev_func = func_ff;
               end else begin
                  ctl.op          = CELL_PUSH;
                  new_frame.valid = 1'b1;
                  new_frame.sp    = (emul_ff && depth_ff != '0) ? top.sp : csp_ff;
                  new_frame.ret   = '0;
                  new_frame.func  = func_ff;
                  depth_in        = depth_ff + 1'b1;
                  ev_v            = (func_ff != '0);
                  ev_kind         = EV_ENTER;
                  ev_func         = func_ff;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Flush the pending beat as the last one of this block.
            if (step) begin
               if (hold_v_ff) begin
                  rsp_in      = hold_ff;
                  rsp_in.last = 1'b1;
                  rsp_v_in    = 1'b1;
                  hold_v_in   = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      depth_x = {6'b0, depth_in};
      if (ev_v) begin
         if (hold_v_ff) begin
            rsp_in   = hold_ff;
            rsp_v_in = 1'b1;
         end
         hold_in.event_kind  = ev_kind;
         hold_in.event_func  = ev_func;
         hold_in.depth_after = depth_x[5:0];
         hold_in.last        = 1'b0;
         hold_v_in           = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         depth_ff  <= '0;
         hold_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         depth_ff  <= depth_in;
         hold_v_ff <= hold_v_in;
         rsp_v_ff  <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff      <= in_in;
      func_ff    <= func_in;
      csp_ff     <= csp_in;
      retcall_ff <= retcall_in;
      emul_ff    <= emul_in;
      is_ret_ff  <= is_ret_in;
      is_call_ff <= is_call_in;
      walk_ff    <= walk_in;
      cnt_ff     <= cnt_in;
      popped_ff  <= popped_in;
      hold_ff    <= hold_in;
      rsp_ff     <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== src/scst_cell.sv =====
// One shadow stack cell: holds a frame, shifts with its neighbors, carries the scan token.
module scst_cell
   import scst_pkg::*;
#(
   parameter bit IS_TOP = 1'b0
) (
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  frame_type    up_frame,
   input  frame_type    down_frame,
   input  logic         up_scan,
   output frame_type    frame_out,
   output logic         scan_out,
   output logic         hit
);

   frame_type frame_ff, frame_in;
   logic      scan_ff, scan_in;
   logic      sp_eq;
   logic      ret_eq;

   assign sp_eq  = (frame_ff.sp == ctl.csp);
   assign ret_eq = (frame_ff.ret == ctl.target);

   always_comb begin
      frame_in = frame_ff;
      scan_in  = 1'b0;
      unique case (ctl.op)
         CELL_PUSH:       frame_in = up_frame;
         CELL_POP:        frame_in = down_frame;
         CELL_SETRET: begin
            if (IS_TOP) begin
               frame_in.ret = ctl.ret_value;
            end
         end
         CELL_SCAN_START: scan_in = IS_TOP;
         CELL_SCAN_STEP:  scan_in = up_scan & sp_eq & frame_ff.valid;
         default:         frame_in = frame_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '{valid: IS_TOP, sp: '0, ret: '0, func: '0};
         scan_ff  <= 1'b0;
      end else begin
         frame_ff <= frame_in;
         scan_ff  <= scan_in;
      end
   end

   assign frame_out = frame_ff;
   assign scan_out  = scan_ff;
   assign hit       = scan_ff & ret_eq & frame_ff.valid;

endmodule
